/* hw/rtl/priority_event_queue_with_timer_bank_defines.svh */
// assertion macros for the priority event queue with timer bank
// used by the top level only; no other dependencies
`ifndef PRIORITY_EVENT_QUEUE_WITH_TIMER_BANK_DEFINES_SVH
`define PRIORITY_EVENT_QUEUE_WITH_TIMER_BANK_DEFINES_SVH
`ifndef SYNTH
`define PETB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PETB_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PETB_ASSERT(lbl, clk, rst_n, prop, msg)
`define PETB_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

/* hw/rtl/petb_pkg.sv */
// shared constants, codes and types of the priority event queue with timer bank
// no dependencies
`timescale 1ns / 1ps
package petb_pkg;
    localparam int QUEUE_DEPTH = 32;
    localparam int LEVELS      = 3;
    localparam int TIMER_COUNT = 8;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W  = 2;
    localparam int TIDX_W = 3;
    localparam int TSEL_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int EV_D   = LEVELS * QUEUE_DEPTH;
    localparam int EV_AW  = $clog2(EV_D);
    localparam int EV_W   = 28;
    localparam int TM_W   = 22;

    localparam logic [2:0] A_POST   = 3'd0;
    localparam logic [2:0] A_TAKE   = 3'd1;
    localparam logic [2:0] A_SET    = 3'd2;
    localparam logic [2:0] A_STOP   = 3'd3;
    localparam logic [2:0] A_RESUME = 3'd4;
    localparam logic [2:0] A_TICK   = 3'd5;
    localparam logic [2:0] A_CLEAR  = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_BADPRIO = 2'd3;

    localparam logic [1:0] T_OFF  = 2'd0;
    localparam logic [1:0] T_RUN  = 2'd1;
    localparam logic [1:0] T_DONE = 2'd2;

    localparam logic REG_CODE = 1'b0;
    localparam logic REG_PRIO = 1'b1;

    // event entry: service, parameter, type
    typedef struct packed {
        logic [3:0]  svc;
        logic [15:0] param;
        logic [7:0]  etype;
    } t_event;

    // timer entry: state, service, count
    typedef struct packed {
        logic [1:0]  st;
        logic [3:0]  svc;
        logic [15:0] cnt;
    } t_timer;
endpackage

/* hw/rtl/priority_event_queue_with_timer_bank.sv */
// priority event queue with timer bank: 3 ring fifos in one event ram, 8 timers in a timer ram
// one word at a time: the next word is taken once the result sits in the output register
// the timer ram walk, one timer per cycle, sets the tick time; ram read latency sets the rest
// reset (sync, active low): fifos empty, timers off, counters zero, registers to defaults
// depends on petb_pkg, petb_ram and priority_event_queue_with_timer_bank_defines.svh
`timescale 1ns / 1ps
`include "priority_event_queue_with_timer_bank_defines.svh"
module priority_event_queue_with_timer_bank
    import petb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_event_type,
    input  logic [15:0] i_event_param,
    input  logic [1:0]  i_event_priority,
    input  logic [3:0]  i_target_service,
    input  logic [2:0]  i_timer_index,
    input  logic [15:0] i_timer_time,
    // result word channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_event_valid,
    output logic [7:0]  o_out_event_type,
    output logic [15:0] o_out_event_param,
    output logic [1:0]  o_out_priority,
    output logic [3:0]  o_out_service,
    output logic [31:0] o_running_time,
    output logic [3:0]  o_expired_count,
    output logic [1:0]  o_timer_state,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_TAKE = 4'd2;
    localparam logic [3:0] S_TRMW = 4'd3;
    localparam logic [3:0] S_TICK = 4'd4;
    localparam logic [3:0] S_FRD  = 4'd5;
    localparam logic [3:0] S_FCAP = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    localparam logic [TSEL_W-1:0] LAST_T = TSEL_W'(TIMER_COUNT - 1);

    // control state
    logic [3:0]             r_state, n_state;
    logic [PTR_W-1:0]       r_wp [LEVELS];
    logic [PTR_W-1:0]       n_wp [LEVELS];
    logic [PTR_W-1:0]       r_rp [LEVELS];
    logic [PTR_W-1:0]       n_rp [LEVELS];
    logic [FILL_W-1:0]      r_fill [LEVELS];
    logic [FILL_W-1:0]      n_fill [LEVELS];
    logic [TIMER_COUNT-1:0] r_tval, n_tval;   // timer entry written since reset
    logic [31:0]            r_ms, n_ms;
    logic                   r_phase, n_phase;
    logic [7:0]             r_code, n_code;
    logic [LVL_W-1:0]       r_tprio, n_tprio;
    logic [TSEL_W-1:0]      r_ti, n_ti;
    logic                   r_rdv;
    logic                   r_ov, n_ov;

    // latched input word
    logic [2:0]  r_act, n_act;
    logic [7:0]  r_etype, n_etype;
    logic [15:0] r_eparam, n_eparam;
    logic [1:0]  r_eprio, n_eprio;
    logic [3:0]  r_svc, n_svc;
    logic [2:0]  r_tidx, n_tidx;
    logic [15:0] r_ttime, n_ttime;

    // result being built
    logic [1:0]  r_status, n_status;
    logic        r_evalid, n_evalid;
    logic [7:0]  r_otype, n_otype;
    logic [15:0] r_oparam, n_oparam;
    logic [1:0]  r_oprio, n_oprio;
    logic [3:0]  r_osvc, n_osvc;
    logic [3:0]  r_exp, n_exp;
    logic [1:0]  r_tstate, n_tstate;

    // output register
    logic [1:0]  r_o_status, n_o_status;
    logic        r_o_evalid, n_o_evalid;
    logic [7:0]  r_o_type, n_o_type;
    logic [15:0] r_o_param, n_o_param;
    logic [1:0]  r_o_prio, n_o_prio;
    logic [3:0]  r_o_svc, n_o_svc;
    logic [31:0] r_o_ms, n_o_ms;
    logic [3:0]  r_o_exp, n_o_exp;
    logic [1:0]  r_o_tstate, n_o_tstate;

    // ram ports
    logic              ev_we;
    logic [EV_AW-1:0]  ev_waddr, ev_raddr;
    t_event            ev_wdata, ev_rdata;
    logic              tm_we;
    logic [TSEL_W-1:0] tm_waddr, tm_raddr;
    t_timer            tm_wdata, tm_rdata;

    // enqueue request shared by post and timer expiry
    logic             enq_req;
    logic [LVL_W-1:0] enq_lvl;
    t_event           enq_data;

    logic             tok;
    logic [TSEL_W-1:0] tsel;
    logic [LVL_W-1:0] tlvl;
    t_timer           tcur;
    logic             take_found;
    logic [LVL_W-1:0] take_lvl;
    logic             cfg_wr;

    petb_ram #(.WIDTH(EV_W), .DEPTH(EV_D)) u_event_ram (
        .i_clk   (i_clk),
        .i_we    (ev_we),
        .i_waddr (ev_waddr),
        .i_wdata (ev_wdata),
        .i_raddr (ev_raddr),
        .o_rdata (ev_rdata)
    );

    petb_ram #(.WIDTH(TM_W), .DEPTH(TIMER_COUNT)) u_timer_ram (
        .i_clk   (i_clk),
        .i_we    (tm_we),
        .i_waddr (tm_waddr),
        .i_wdata (tm_wdata),
        .i_raddr (tm_raddr),
        .o_rdata (tm_rdata)
    );

    function automatic logic [EV_AW-1:0] ev_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [PTR_W-1:0] ptr);
        ev_addr = EV_AW'(int'(lvl) * QUEUE_DEPTH + int'(ptr));
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (int'(p) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(int'(p) + 1);
    endfunction

    assign tok  = (int'(r_tidx) < TIMER_COUNT);
    assign tsel = TSEL_W'(r_tidx);
    // an out-of-range expiry level falls back to the top level
    assign tlvl = (int'(r_tprio) >= LEVELS) ? LVL_W'(LEVELS - 1) : r_tprio;
    // a never-written timer reads as off and zero
    assign tcur = r_rdv ? tm_rdata : '0;

    // highest non-empty level
    always_comb begin
        take_found = 1'b0;
        take_lvl   = '0;
        for (int k = 0; k < LEVELS; k++) begin
            if (r_fill[k] != '0) begin
                take_found = 1'b1;
                take_lvl   = LVL_W'(k);
            end
        end
    end

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CODE) begin
            prdata = 32'(r_code);
        end else begin
            prdata = 32'(r_tprio);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_fill   = r_fill;
        n_tval   = r_tval;
        n_ms     = r_ms;
        n_phase  = r_phase;
        n_code   = r_code;
        n_tprio  = r_tprio;
        n_ti     = r_ti;
        n_ov     = r_ov;
        n_act    = r_act;
        n_etype  = r_etype;
        n_eparam = r_eparam;
        n_eprio  = r_eprio;
        n_svc    = r_svc;
        n_tidx   = r_tidx;
        n_ttime  = r_ttime;
        n_status = r_status;
        n_evalid = r_evalid;
        n_otype  = r_otype;
        n_oparam = r_oparam;
        n_oprio  = r_oprio;
        n_osvc   = r_osvc;
        n_exp    = r_exp;
        n_tstate = r_tstate;
        n_o_status = r_o_status;
        n_o_evalid = r_o_evalid;
        n_o_type   = r_o_type;
        n_o_param  = r_o_param;
        n_o_prio   = r_o_prio;
        n_o_svc    = r_o_svc;
        n_o_ms     = r_o_ms;
        n_o_exp    = r_o_exp;
        n_o_tstate = r_o_tstate;
        ev_we    = 1'b0;
        ev_waddr = '0;
        ev_wdata = '0;
        ev_raddr = '0;
        tm_we    = 1'b0;
        tm_waddr = tsel;
        tm_wdata = '0;
        tm_raddr = '0;
        enq_req  = 1'b0;
        enq_lvl  = '0;
        enq_data = '0;

        // result taken downstream
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        if (cfg_wr) begin
            if (paddr[2] == REG_CODE) begin
                n_code = pwdata[7:0];
            end else begin
                n_tprio = pwdata[LVL_W-1:0];
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_act    = i_action;
                    n_etype  = i_event_type;
                    n_eparam = i_event_param;
                    n_eprio  = i_event_priority;
                    n_svc    = i_target_service;
                    n_tidx   = i_timer_index;
                    n_ttime  = i_timer_time;
                    n_status = ST_OK;
                    n_evalid = 1'b0;
                    n_otype  = '0;
                    n_oparam = '0;
                    n_oprio  = '0;
                    n_osvc   = '0;
                    n_exp    = '0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FRD;
                case (r_act)
                    A_POST: begin
                        if (int'(r_eprio) >= LEVELS) begin
                            n_status = ST_BADPRIO;
                        end else begin
                            enq_req  = 1'b1;
                            enq_lvl  = r_eprio;
                            enq_data = '{svc: r_svc, param: r_eparam, etype: r_etype};
                        end
                    end
                    A_TAKE: begin
                        if (take_found) begin
                            ev_raddr         = ev_addr(take_lvl, r_rp[take_lvl]);
                            n_rp[take_lvl]   = ptr_inc(r_rp[take_lvl]);
                            n_fill[take_lvl] = r_fill[take_lvl] - 1'b1;
                            n_evalid         = 1'b1;
                            n_oprio          = take_lvl;
                            n_state          = S_TAKE;
                        end else begin
                            n_status = ST_EMPTY;
                        end
                    end
                    A_SET: begin
                        if (tok) begin
                            tm_we        = 1'b1;
                            tm_wdata     = '{st: T_RUN, svc: r_svc, cnt: r_ttime};
                            n_tval[tsel] = 1'b1;
                        end
                    end
                    A_STOP, A_RESUME: begin
                        tm_raddr = tsel;
                        n_state  = S_TRMW;
                    end
                    A_TICK: begin
                        n_phase = ~r_phase;
                        // every second tick counts a millisecond
                        if (r_phase) begin
                            n_ms     = r_ms + 32'd1;
                            tm_raddr = '0;
                            n_ti     = '0;
                            n_state  = S_TICK;
                        end
                    end
                    A_CLEAR: begin
                        n_ms = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_TAKE: begin
                n_otype  = ev_rdata.etype;
                n_oparam = ev_rdata.param;
                n_osvc   = ev_rdata.svc;
                n_state  = S_FRD;
            end
            S_TRMW: begin
                if (tok) begin
                    tm_we        = 1'b1;
                    tm_wdata     = tcur;
                    tm_wdata.st  = (r_act == A_STOP) ? T_OFF : T_RUN;
                    n_tval[tsel] = 1'b1;
                end
                n_state = S_FRD;
            end
            S_TICK: begin
                // walk one timer a cycle, next read issued alongside
                if (r_ti != LAST_T) begin
                    tm_raddr = r_ti + 1'b1;
                    n_ti     = r_ti + 1'b1;
                end else begin
                    n_state = S_FRD;
                end
                if (tcur.st == T_RUN) begin
                    tm_we          = 1'b1;
                    tm_waddr       = r_ti;
                    tm_wdata       = tcur;
                    tm_wdata.cnt   = tcur.cnt - 16'd1;
                    n_tval[r_ti]   = 1'b1;
                    if (tcur.cnt == 16'd1) begin
                        tm_wdata.st = T_DONE;
                        n_exp       = r_exp + 4'd1;
                        enq_req     = 1'b1;
                        enq_lvl     = tlvl;
                        enq_data    = '{svc: tcur.svc, param: 16'(r_ti), etype: r_code};
                    end
                end
            end
            S_FRD: begin
                tm_raddr = tsel;
                n_state  = S_FCAP;
            end
            S_FCAP: begin
                n_tstate = tok ? tcur.st : T_OFF;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_evalid = r_evalid;
                    n_o_type   = r_otype;
                    n_o_param  = r_oparam;
                    n_o_prio   = r_oprio;
                    n_o_svc    = r_osvc;
                    n_o_ms     = r_ms;
                    n_o_exp    = r_exp;
                    n_o_tstate = r_tstate;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // ring fifo write; a full level drops the word
        if (enq_req) begin
            if (int'(r_fill[enq_lvl]) >= QUEUE_DEPTH) begin
                n_status = ST_FULL;
            end else begin
                ev_we           = 1'b1;
                ev_waddr        = ev_addr(enq_lvl, r_wp[enq_lvl]);
                ev_wdata        = enq_data;
                n_wp[enq_lvl]   = ptr_inc(r_wp[enq_lvl]);
                n_fill[enq_lvl] = r_fill[enq_lvl] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int k = 0; k < LEVELS; k++) begin
                r_wp[k]   <= '0;
                r_rp[k]   <= '0;
                r_fill[k] <= '0;
            end
            r_tval  <= '0;
            r_ms    <= '0;
            r_phase <= 1'b0;
            r_code  <= 8'd1;
            r_tprio <= 2'd2;
            r_ti    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_fill  <= n_fill;
            r_tval  <= n_tval;
            r_ms    <= n_ms;
            r_phase <= n_phase;
            r_code  <= n_code;
            r_tprio <= n_tprio;
            r_ti    <= n_ti;
            r_ov    <= n_ov;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_rdv      <= r_tval[tm_raddr];
        r_act      <= n_act;
        r_etype    <= n_etype;
        r_eparam   <= n_eparam;
        r_eprio    <= n_eprio;
        r_svc      <= n_svc;
        r_tidx     <= n_tidx;
        r_ttime    <= n_ttime;
        r_status   <= n_status;
        r_evalid   <= n_evalid;
        r_otype    <= n_otype;
        r_oparam   <= n_oparam;
        r_oprio    <= n_oprio;
        r_osvc     <= n_osvc;
        r_exp      <= n_exp;
        r_tstate   <= n_tstate;
        r_o_status <= n_o_status;
        r_o_evalid <= n_o_evalid;
        r_o_type   <= n_o_type;
        r_o_param  <= n_o_param;
        r_o_prio   <= n_o_prio;
        r_o_svc    <= n_o_svc;
        r_o_ms     <= n_o_ms;
        r_o_exp    <= n_o_exp;
        r_o_tstate <= n_o_tstate;
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_ov;
    assign o_status          = r_o_status;
    assign o_event_valid     = r_o_evalid;
    assign o_out_event_type  = r_o_type;
    assign o_out_event_param = r_o_param;
    assign o_out_priority    = r_o_prio;
    assign o_out_service     = r_o_svc;
    assign o_running_time    = r_o_ms;
    assign o_expired_count   = r_o_exp;
    assign o_timer_state     = r_o_tstate;

    // fill counts of the lowest and the top level never pass the fifo depth
    `PETB_ASSERT(a_fill_bound, i_clk, i_rst_n, (int'(r_fill[0]) <= QUEUE_DEPTH) && (int'(r_fill[LEVELS-1]) <= QUEUE_DEPTH), "fifo fill count above depth")
    // a returned event always comes with ok status
    `PETB_ASSERT(a_take_ok, i_clk, i_rst_n, (o_valid && o_event_valid) |-> (o_status == ST_OK), "event returned with error status")
    // the expiry count stays within the timer bank
    `PETB_ASSERT_NR(a_exp_bound, i_clk, (i_rst_n && o_valid) |-> (int'(o_expired_count) <= TIMER_COUNT), "expired count above timer count")
endmodule

/* hw/rtl/petb_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
module petb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
